>>> rtl/tsc_pkg.sv
// tsc_pkg: shared constants, codes and types for the tag set compare block.
// No dependencies; every other file but tsc_ram takes names from here by scope.
`timescale 1ns / 1ps

package tsc_pkg;

    localparam int SET_DEPTH = 64;
    localparam int IDX_W     = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int TAG_W     = 32;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SET_DEPTH);

    // item commands
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    // evaluate modes
    localparam logic [1:0] MODE_WITHIN = 2'd0;
    localparam logic [1:0] MODE_MUTUAL = 2'd1;

    // result codes
    localparam logic [2:0] CODE_NO_MATCH      = 3'd0;
    localparam logic [2:0] CODE_WITH_NULL     = 3'd1;
    localparam logic [2:0] CODE_WITHOUT_NULL  = 3'd2;
    localparam logic [2:0] CODE_EXACT         = 3'd3;
    localparam logic [2:0] CODE_BAD_MODE      = 3'd4;
    localparam logic [2:0] CODE_CAPACITY      = 3'd5;

    // set status handed from the sequencer to the evaluator
    typedef struct packed {
        logic [CNT_W-1:0] first_distinct;
        logic [CNT_W-1:0] second_distinct;
        logic [CNT_W-1:0] covered_count;
        logic             first_had_null;
        logic             first_nonempty;
        logic             second_nonempty;
        logic             second_missed;
        logic             store_overflow;
    } set_status_t;

endpackage

>>> rtl/tsc_ram.sv
// tsc_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module tsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tsc_eval.sv
// tsc_eval: turns the accumulated set status into a result code.
// Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_eval (
    input  tsc_pkg::set_status_t status,
    input  logic                 first_absent,
    input  logic                 second_absent,
    input  logic [1:0]           eval_mode,
    output logic [2:0]           code
);

    always_comb
    begin
        code = tsc_pkg::CODE_NO_MATCH;
        if (first_absent || second_absent)
        begin
            code = tsc_pkg::CODE_NO_MATCH;
        end
        else if (!(eval_mode inside {tsc_pkg::MODE_WITHIN, tsc_pkg::MODE_MUTUAL}))
        begin
            code = tsc_pkg::CODE_BAD_MODE;
        end
        else if (status.store_overflow)
        begin
            code = tsc_pkg::CODE_CAPACITY;
        end
        else if (!status.first_nonempty)
        begin
            code = status.second_nonempty ? tsc_pkg::CODE_NO_MATCH : tsc_pkg::CODE_EXACT;
        end
        else if (!status.second_nonempty)
        begin
            code = tsc_pkg::CODE_NO_MATCH;
        end
        else
        begin
            if (status.second_missed)
            begin
                code = status.first_had_null ? tsc_pkg::CODE_WITH_NULL
                                             : tsc_pkg::CODE_NO_MATCH;
            end
            else
            begin
                code = (status.first_distinct == status.second_distinct)
                       ? tsc_pkg::CODE_EXACT : tsc_pkg::CODE_WITHOUT_NULL;
            end
            // mutual: every stored A value must have been hit by some B value
            if (eval_mode == tsc_pkg::MODE_MUTUAL
                && status.covered_count != status.first_distinct)
            begin
                code = tsc_pkg::CODE_NO_MATCH;
            end
        end
    end

endmodule

>>> rtl/tag_set_compare.sv
// tag_set_compare: top level; load sequencer around two value RAMs and the evaluator.
// Depends on tsc_pkg, tsc_ram, tsc_eval.
`timescale 1ns / 1ps

// Compares two sets of signed 32-bit tags. Send the A elements with command
// load A, then the B elements with load B, then one evaluate item; only the
// evaluate item produces a result, shown on outcome_code for exactly one cycle
// with result_valid high, and the receiver cannot stall it. Evaluate also
// clears all set state. An item is taken when start is high and busy is low.
// A null load, an evaluate and a reserved command leave busy low, so the next
// item can be taken at the very next edge. A non-null load of A scans the
// distinct A values held so far; a non-null load of B scans A and B together,
// as many entries as the larger of the two counts. The scan reads one RAM
// entry per cycle; a load holds busy through the scan, wait and finish states
// in that order (straight to finish when there is nothing to scan), and the
// next item is taken once the block is back in idle.
// Each side holds SET_DEPTH distinct values; a new value that finds its side full is
// dropped, and evaluate reports capacity exceeded unless a side is absent or the
// mode is unknown. Each A value carries its covered mark beside it in the first
// RAM: an append writes the mark clear and a B hit sets it. No RAM clearing pass
// is needed after reset or evaluate: the fill counts bound every scan.

module tag_set_compare (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               command,
    input  logic signed [31:0]       tag_value,
    input  logic                     element_is_null,
    input  logic                     first_absent,
    input  logic                     second_absent,
    input  logic [1:0]               eval_mode,
    output logic                     result_valid,
    output logic [2:0]               outcome_code
);

    localparam int IDX_W = tsc_pkg::IDX_W;
    localparam int CNT_W = tsc_pkg::CNT_W;
    localparam int TAG_W = tsc_pkg::TAG_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [TAG_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               pend_reg, pend_next;
    logic [CNT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               hit_reg, hit_next;
    logic [IDX_W-1:0]   hit_idx_reg, hit_idx_next;
    logic               hit_cov_reg, hit_cov_next;
    logic               dup_reg, dup_next;
    tsc_pkg::set_status_t status_reg, status_next;
    logic               result_valid_reg, result_valid_next;
    logic [2:0]         outcome_code_reg, outcome_code_next;

    logic               accept;
    logic [2:0]         eval_code;
    logic [TAG_W:0]     a_rdata;
    logic [TAG_W:0]     a_wdata;
    logic [IDX_W-1:0]   a_waddr;
    logic [TAG_W-1:0]   b_rdata;
    logic               a_we, b_we, rd_en;
    logic               a_match, b_match;
    logic [CNT_W-1:0]   scan_len;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign rd_en  = (state_reg == ST_SCAN);

    // A side: append when the scan found no copy and the side has room,
    // or mark the A entry that a B value hit for the first time
    assign a_we = (state_reg == ST_FINISH)
                  && (((cmd_reg == tsc_pkg::CMD_LOAD_A) && !dup_reg
                       && (status_reg.first_distinct != tsc_pkg::DEPTH_CNT))
                      || ((cmd_reg == tsc_pkg::CMD_LOAD_B) && hit_reg && !hit_cov_reg));
    assign a_waddr = (cmd_reg == tsc_pkg::CMD_LOAD_A) ? status_reg.first_distinct[IDX_W-1:0]
                                                      : hit_idx_reg;
    // covered mark on top of the value: clear on append, set on a B hit
    assign a_wdata = {(cmd_reg == tsc_pkg::CMD_LOAD_B), val_reg};
    assign b_we = (state_reg == ST_FINISH) && (cmd_reg == tsc_pkg::CMD_LOAD_B)
                  && !dup_reg && (status_reg.second_distinct != tsc_pkg::DEPTH_CNT);

    tsc_ram #(.WIDTH(TAG_W + 1), .DEPTH(tsc_pkg::SET_DEPTH)) u_first_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (a_rdata)
    );

    tsc_ram #(.WIDTH(TAG_W), .DEPTH(tsc_pkg::SET_DEPTH)) u_second_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (status_reg.second_distinct[IDX_W-1:0]),
        .wdata (val_reg),
        .re    (rd_en),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (b_rdata)
    );

    tsc_eval u_eval (
        .status        (status_reg),
        .first_absent  (first_absent),
        .second_absent (second_absent),
        .eval_mode     (eval_mode),
        .code          (eval_code)
    );

    // compare the entry read in the previous cycle; past the fill count the
    // RAM data is stale and must not count
    assign a_match = pend_reg && (pend_idx_reg < status_reg.first_distinct)
                     && (a_rdata[TAG_W-1:0] == val_reg);
    assign b_match = pend_reg && (pend_idx_reg < status_reg.second_distinct)
                     && (b_rdata == val_reg);

    // B loads walk both sides at once, so scan the longer of the two
    always_comb
    begin
        if (command == tsc_pkg::CMD_LOAD_A
            || status_reg.first_distinct >= status_reg.second_distinct)
        begin
            scan_len = status_reg.first_distinct;
        end
        else
        begin
            scan_len = status_reg.second_distinct;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        val_next          = val_reg;
        lim_next          = lim_reg;
        idx_next          = idx_reg;
        pend_next         = (state_reg == ST_SCAN);
        pend_idx_next     = idx_reg;
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        hit_cov_next      = hit_cov_reg;
        dup_next          = dup_reg;
        status_next       = status_reg;
        result_valid_next = 1'b0;
        outcome_code_next = outcome_code_reg;

        // collect scan hits
        if (cmd_reg == tsc_pkg::CMD_LOAD_A)
        begin
            if (a_match)
            begin
                dup_next = 1'b1;
            end
        end
        else
        begin
            if (a_match)
            begin
                hit_next     = 1'b1;
                hit_idx_next = pend_idx_reg[IDX_W-1:0];
                hit_cov_next = a_rdata[TAG_W];
            end
            if (b_match)
            begin
                dup_next = 1'b1;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = command;
                    val_next = tag_value;
                    hit_next = 1'b0;
                    dup_next = 1'b0;
                    idx_next = '0;
                    lim_next = scan_len;
                    case (command)
                        tsc_pkg::CMD_LOAD_A:
                        begin
                            status_next.first_nonempty = 1'b1;
                            if (element_is_null)
                            begin
                                status_next.first_had_null = 1'b1;
                            end
                            else
                            begin
                                state_next = (scan_len == '0) ? ST_FINISH : ST_SCAN;
                            end
                        end
                        tsc_pkg::CMD_LOAD_B:
                        begin
                            status_next.second_nonempty = 1'b1;
                            if (!element_is_null)
                            begin
                                state_next = (scan_len == '0) ? ST_FINISH : ST_SCAN;
                            end
                        end
                        tsc_pkg::CMD_EVAL:
                        begin
                            // emit and drop all set state
                            result_valid_next = 1'b1;
                            outcome_code_next = eval_code;
                            status_next       = '0;
                        end
                        default:
                        begin
                            // reserved command: drop the item
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == lim_reg)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                // last read is compared this cycle
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
                if (cmd_reg == tsc_pkg::CMD_LOAD_A)
                begin
                    if (!dup_reg)
                    begin
                        if (status_reg.first_distinct == tsc_pkg::DEPTH_CNT)
                        begin
                            status_next.store_overflow = 1'b1;
                        end
                        else
                        begin
                            status_next.first_distinct = status_reg.first_distinct + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (hit_reg)
                    begin
                        if (!hit_cov_reg)
                        begin
                            status_next.covered_count = status_reg.covered_count + 1'b1;
                        end
                    end
                    else
                    begin
                        status_next.second_missed = 1'b1;
                    end
                    if (!dup_reg)
                    begin
                        if (status_reg.second_distinct == tsc_pkg::DEPTH_CNT)
                        begin
                            status_next.store_overflow = 1'b1;
                        end
                        else
                        begin
                            status_next.second_distinct = status_reg.second_distinct + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= tsc_pkg::CMD_LOAD_A;
            lim_reg          <= '0;
            idx_reg          <= '0;
            pend_reg         <= 1'b0;
            hit_reg          <= 1'b0;
            dup_reg          <= 1'b0;
            status_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            lim_reg          <= lim_next;
            idx_reg          <= idx_next;
            pend_reg         <= pend_next;
            hit_reg          <= hit_next;
            dup_reg          <= dup_next;
            status_reg       <= status_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        val_reg          <= val_next;
        pend_idx_reg     <= pend_idx_next;
        hit_idx_reg      <= hit_idx_next;
        hit_cov_reg      <= hit_cov_next;
        outcome_code_reg <= outcome_code_next;
    end

    assign result_valid = result_valid_reg;
    assign outcome_code = outcome_code_reg;

endmodule

>>> rtl/tsc_checker.sv
// tsc_checker: port-level assertions for tag_set_compare, bound to the top level.
// Depends on tsc_pkg and tag_set_compare.
`timescale 1ns / 1ps

module tsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] command,
    input logic       element_is_null,
    input logic       result_valid,
    input logic [2:0] outcome_code
);

    // evaluate always answers in the next cycle
    a_eval_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && command == tsc_pkg::CMD_EVAL |=> result_valid)
        else $error("evaluate item gave no result");

    // loads never produce a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == tsc_pkg::CMD_LOAD_A
                           || command == tsc_pkg::CMD_LOAD_B) |=> !result_valid)
        else $error("load item produced a result");

    // null loads need no scan
    a_null_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && element_is_null && (command == tsc_pkg::CMD_LOAD_A
                           || command == tsc_pkg::CMD_LOAD_B) |=> !busy)
        else $error("null load held the block busy");

    // a result only appears while idle, and carries a defined code
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy && outcome_code <= tsc_pkg::CODE_CAPACITY)
        else $error("result while busy or with undefined code");

endmodule

bind tag_set_compare tsc_checker u_tsc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .element_is_null (element_is_null),
    .result_valid    (result_valid),
    .outcome_code    (outcome_code)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for tag_set_compare, fed with directed and random item streams.
// Scores every result against an in-bench model of the two tag sets; needs tsc_pkg and the RTL.

module testbench;

    // command and modes the package leaves unnamed
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam logic [1:0] MODE_SPARE_2 = 2'd2;
    localparam logic [1:0] MODE_SPARE_3 = 2'd3;

    localparam logic [tsc_pkg::TAG_W-1:0] TAG_MIN  = 32'h8000_0000;
    localparam logic [tsc_pkg::TAG_W-1:0] TAG_MAX  = 32'h7FFF_FFFF;
    localparam logic [tsc_pkg::TAG_W-1:0] TAG_ONES = 32'hFFFF_FFFF;

    localparam int RANDOM_ITEMS = 1400;
    // worst case is a full-depth scan per item plus sender gaps; allow several times that
    localparam int CYCLE_LIMIT  = 800000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [1:0]        command;
        logic signed [31:0] tag_value;
        logic              element_is_null;
        logic              first_absent;
        logic              second_absent;
        logic [1:0]        eval_mode;
        int                idle_pct;
        bit                drain;
    } tag_item_t;

    logic               clk             = 1'b0;
    logic               rst_n           = 1'b0;
    logic               start           = 1'b0;
    logic [1:0]         command         = tsc_pkg::CMD_LOAD_A;
    logic signed [31:0] tag_value       = '0;
    logic               element_is_null = 1'b0;
    logic               first_absent    = 1'b0;
    logic               second_absent   = 1'b0;
    logic [1:0]         eval_mode       = tsc_pkg::MODE_WITHIN;
    logic               busy;
    logic               result_valid;
    logic [2:0]         outcome_code;

    tag_set_compare u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .tag_value       (tag_value),
        .element_is_null (element_is_null),
        .first_absent    (first_absent),
        .second_absent   (second_absent),
        .eval_mode       (eval_mode),
        .result_valid    (result_valid),
        .outcome_code    (outcome_code)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Set model: the distinct tags of each side, the A entries hit by some
    // B tag, and the flags that evaluate looks at.
    // ------------------------------------------------------------------
    logic [tsc_pkg::TAG_W-1:0] a_tags [tsc_pkg::SET_DEPTH];
    bit                        a_hit  [tsc_pkg::SET_DEPTH];
    logic [tsc_pkg::TAG_W-1:0] b_tags [tsc_pkg::SET_DEPTH];
    int               a_fill;
    int               b_fill;
    bit               a_null;
    bit               a_seen;
    bit               b_seen;
    bit               b_miss;
    bit               overflow_seen;

    tag_item_t  pending_q [$];   // items waiting for the driver
    logic [2:0] code_q    [$];   // predicted result codes, oldest first
    tag_item_t  on_port;         // item currently offered on the ports
    bit         offering    = 1'b0;
    int         gap_pct     = 12;
    bit         drain_next  = 1'b0;
    int         queued_items = 0;
    int         items_taken  = 0;
    int         results_seen = 0;
    int         error_count  = 0;
    int         cycle_count  = 0;
    int         code_tally [8];

    task automatic flag_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // index of a tag in one side's store, or -1 when it is not there
    function automatic int find_tag(input logic [tsc_pkg::TAG_W-1:0] v, input bit side_b);
        int n;
        n = side_b ? b_fill : a_fill;
        for (int k = 0; k < n; k++)
        begin
            if ((side_b ? b_tags[k] : a_tags[k]) == v)
                return k;
        end
        return -1;
    endfunction

    task automatic clear_sets();
        for (int k = 0; k < tsc_pkg::SET_DEPTH; k++)
            a_hit[k] = 1'b0;
        a_fill        = 0;
        b_fill        = 0;
        a_null        = 1'b0;
        a_seen        = 1'b0;
        b_seen        = 1'b0;
        b_miss        = 1'b0;
        overflow_seen = 1'b0;
    endtask

    // Advance the set model by one accepted item; evaluate queues a code.
    task automatic track_item(input tag_item_t it);
        int         hit;
        logic [2:0] code;
        case (it.command)
            tsc_pkg::CMD_LOAD_A:
            begin
                a_seen = 1'b1;
                if (it.element_is_null)
                    a_null = 1'b1;
                else if (find_tag(it.tag_value, 1'b0) < 0)
                begin
                    if (a_fill >= tsc_pkg::SET_DEPTH)
                        overflow_seen = 1'b1;
                    else
                    begin
                        a_tags[a_fill] = it.tag_value;
                        a_hit[a_fill]  = 1'b0;
                        a_fill++;
                    end
                end
            end
            tsc_pkg::CMD_LOAD_B:
            begin
                b_seen = 1'b1;
                if (!it.element_is_null)
                begin
                    // B is compared with A as it stands right now
                    hit = find_tag(it.tag_value, 1'b0);
                    if (hit >= 0)
                        a_hit[hit] = 1'b1;
                    else
                        b_miss = 1'b1;
                    if (find_tag(it.tag_value, 1'b1) < 0)
                    begin
                        if (b_fill >= tsc_pkg::SET_DEPTH)
                            overflow_seen = 1'b1;
                        else
                        begin
                            b_tags[b_fill] = it.tag_value;
                            b_fill++;
                        end
                    end
                end
            end
            tsc_pkg::CMD_EVAL:
            begin
                // priority: absent, unknown mode, capacity, empty sides, miss
                if (it.first_absent || it.second_absent)
                    code = tsc_pkg::CODE_NO_MATCH;
                else if (it.eval_mode != tsc_pkg::MODE_WITHIN
                         && it.eval_mode != tsc_pkg::MODE_MUTUAL)
                    code = tsc_pkg::CODE_BAD_MODE;
                else if (overflow_seen)
                    code = tsc_pkg::CODE_CAPACITY;
                else if (!a_seen)
                    code = b_seen ? tsc_pkg::CODE_NO_MATCH : tsc_pkg::CODE_EXACT;
                else if (!b_seen)
                    code = tsc_pkg::CODE_NO_MATCH;
                else
                begin
                    if (b_miss)
                        code = a_null ? tsc_pkg::CODE_WITH_NULL : tsc_pkg::CODE_NO_MATCH;
                    else
                        code = (a_fill == b_fill) ? tsc_pkg::CODE_EXACT
                                                  : tsc_pkg::CODE_WITHOUT_NULL;
                    // mutual mode drops to no match if any A tag went unhit
                    if (it.eval_mode == tsc_pkg::MODE_MUTUAL)
                    begin
                        for (int k = 0; k < a_fill; k++)
                        begin
                            if (!a_hit[k])
                                code = tsc_pkg::CODE_NO_MATCH;
                        end
                    end
                end
                code_q.push_back(code);
                code_tally[code]++;
                clear_sets();
            end
            default:
            begin
                // reserved command: no result, state untouched
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers: fields an item does not use are filled at random
    // so that every port bit toggles.
    // ------------------------------------------------------------------
    task automatic push_load(input logic [1:0] cmd, input logic [tsc_pkg::TAG_W-1:0] v,
                             input logic nul);
        tag_item_t it;
        it.command         = cmd;
        it.tag_value       = v;
        it.element_is_null = nul;
        it.first_absent    = 1'($urandom_range(0, 1));
        it.second_absent   = 1'($urandom_range(0, 1));
        it.eval_mode       = 2'($urandom_range(0, 3));
        it.idle_pct        = gap_pct;
        it.drain           = drain_next;
        drain_next         = 1'b0;
        pending_q.push_back(it);
        if (cmd != CMD_RESERVED)
            queued_items++;
    endtask

    task automatic push_eval(input logic a_abs, input logic b_abs, input logic [1:0] mode);
        tag_item_t it;
        it.command         = tsc_pkg::CMD_EVAL;
        it.tag_value       = $urandom;
        it.element_is_null = 1'($urandom_range(0, 1));
        it.first_absent    = a_abs;
        it.second_absent   = b_abs;
        it.eval_mode       = mode;
        it.idle_pct        = gap_pct;
        it.drain           = drain_next;
        drain_next         = 1'b0;
        pending_q.push_back(it);
        queued_items++;
    endtask

    // half from a small pool so that tags collide, some extremes, some anything
    function automatic logic [tsc_pkg::TAG_W-1:0] pick_tag();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return $urandom_range(0, 7);
            4:          return TAG_MIN;
            5:          return TAG_MAX;
            6:          return TAG_ONES;
            default:    return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending item, hold it until start && !busy,
    // then feed it to the set model. Start gets one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        tag_item_t nxt;
        logic      go;
        go = start;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                track_item(on_port);
                items_taken++;
                offering = 1'b0;
                go       = 1'b0;
            end
            if (!offering && pending_q.size() > 0)
            begin
                // a drain item waits for every predicted result; else idle at random
                if (!(pending_q[0].drain && code_q.size() > 0)
                    && $urandom_range(0, 99) >= pending_q[0].idle_pct)
                begin
                    nxt             = pending_q.pop_front();
                    on_port         = nxt;
                    command         <= nxt.command;
                    tag_value       <= nxt.tag_value;
                    element_is_null <= nxt.element_is_null;
                    first_absent    <= nxt.first_absent;
                    second_absent   <= nxt.second_absent;
                    eval_mode       <= nxt.eval_mode;
                    offering        = 1'b1;
                    go              = 1'b1;
                end
            end
        end
        start <= go;
    end

    // Monitor: each strobed result is matched against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        logic [2:0] want;
        if (rst_n && result_valid)
        begin
            if (code_q.size() == 0)
                flag_mismatch($sformatf("result code %0d with nothing predicted", outcome_code));
            else
            begin
                want = code_q.pop_front();
                results_seen++;
                if (outcome_code !== want)
                    flag_mismatch($sformatf("result code %0d, predicted %0d",
                                            outcome_code, want));
            end
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: build the item stream, release reset, drain, score.
    // ------------------------------------------------------------------
    initial
    begin : main
        logic [tsc_pkg::TAG_W-1:0] a_pick [$];
        logic [tsc_pkg::TAG_W-1:0] v;
        logic [1:0]       mode;
        bit               big;
        bit               nul;
        int               na;
        int               nb;
        int               base;
        int               shift;
        int               last_gap;

        clear_sets();
        for (int k = 0; k < 8; k++)
            code_tally[k] = 0;

        // directed part
        gap_pct = 12;
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_WITHIN);            // both sides empty
        push_load(tsc_pkg::CMD_LOAD_A, TAG_MAX, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_A, TAG_MIN, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_B, TAG_MIN, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_B, TAG_MAX, 1'b0);
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_MUTUAL);            // extremes, exact in mutual
        push_load(tsc_pkg::CMD_LOAD_A, '0, 1'b1);               // null in A acts as wildcard
        push_load(tsc_pkg::CMD_LOAD_A, TAG_ONES, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_A, TAG_ONES, 1'b0);         // duplicate dropped
        push_load(tsc_pkg::CMD_LOAD_B, 32'd5, 1'b0);            // miss covered by the null
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_WITHIN);
        push_load(tsc_pkg::CMD_LOAD_A, 32'd1, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_A, 32'd2, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_B, 32'd1, 1'b0);
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_WITHIN);            // B within A, counts differ
        push_load(tsc_pkg::CMD_LOAD_B, '0, 1'b1);               // only A empty
        push_load(CMD_RESERVED, TAG_ONES, 1'b1);                // reserved command ignored
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_WITHIN);
        push_eval(1'b0, 1'b0, MODE_SPARE_2);                    // unknown modes
        push_eval(1'b0, 1'b0, MODE_SPARE_3);
        push_load(tsc_pkg::CMD_LOAD_A, 32'd7, 1'b0);
        push_eval(1'b1, 1'b0, tsc_pkg::MODE_WITHIN);            // A absent with elements
        push_load(tsc_pkg::CMD_LOAD_B, 32'd9, 1'b0);            // B before A, out of order
        push_load(tsc_pkg::CMD_LOAD_A, 32'd9, 1'b0);
        push_eval(1'b0, 1'b1, tsc_pkg::MODE_MUTUAL);            // B absent wins
        push_load(tsc_pkg::CMD_LOAD_B, 32'd9, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_A, 32'd9, 1'b0);
        push_load(tsc_pkg::CMD_LOAD_B, 32'd9, 1'b0);            // late hit of an A entry
        push_eval(1'b0, 1'b0, tsc_pkg::MODE_MUTUAL);

        // random part: mostly well-formed A/B/evaluate sequences
        queued_items = 0;
        last_gap     = -1;
        while (queued_items < RANDOM_ITEMS)
        begin
            if (queued_items < RANDOM_ITEMS / 3)
                gap_pct = 12;
            else if (queued_items < 2 * RANDOM_ITEMS / 3)
                gap_pct = 51;
            else
                gap_pct = 0;
            // hold off until the block has drained at each phase change and now and then
            if (gap_pct != last_gap || $urandom_range(0, 7) == 0)
                drain_next = 1'b1;
            last_gap = gap_pct;

            a_pick.delete();
            big   = ($urandom_range(0, 99) < 3);
            na    = big ? $urandom_range(60, 68) : $urandom_range(0, 6);
            nb    = big ? $urandom_range(60, 68) : $urandom_range(0, 6);
            base  = $urandom;
            shift = $urandom_range(0, 2);

            for (int i = 0; i < na; i++)
            begin
                v   = big ? base + i : pick_tag();
                nul = !big && ($urandom_range(0, 99) < 12);
                push_load(tsc_pkg::CMD_LOAD_A, v, nul);
                if (!nul)
                    a_pick.push_back(v);
            end
            for (int j = 0; j < nb; j++)
            begin
                if (big)
                    v = base + j + shift;
                else if (a_pick.size() > 0 && $urandom_range(0, 99) < 70)
                    v = a_pick[$urandom_range(0, a_pick.size() - 1)];
                else
                    v = pick_tag();
                nul = !big && ($urandom_range(0, 99) < 10);
                push_load(tsc_pkg::CMD_LOAD_B, v, nul);
                // noise: a reserved command or an A load that arrives late
                if (!big && $urandom_range(0, 99) < 5)
                begin
                    if ($urandom_range(0, 1))
                        push_load(CMD_RESERVED, $urandom, 1'($urandom_range(0, 1)));
                    else
                        push_load(tsc_pkg::CMD_LOAD_A, pick_tag(), 1'($urandom_range(0, 1)));
                end
            end

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: mode = tsc_pkg::MODE_WITHIN;
                5, 6, 7, 8:    mode = tsc_pkg::MODE_MUTUAL;
                default:       mode = $urandom_range(0, 1) ? MODE_SPARE_2 : MODE_SPARE_3;
            endcase
            push_eval($urandom_range(0, 99) < 6, $urandom_range(0, 99) < 6, mode);
        end

        // single reset at the start of the run
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the stream to be taken, the results to arrive, then settle
        while (pending_q.size() > 0 || offering)
            @(negedge clk);
        while (code_q.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("run: %0d items taken, %0d results checked, %0d mismatches",
                 items_taken, results_seen, error_count);
        $display("run: outcomes none %0d, null %0d, within %0d, exact %0d, mode %0d, cap %0d",
                 code_tally[tsc_pkg::CODE_NO_MATCH], code_tally[tsc_pkg::CODE_WITH_NULL],
                 code_tally[tsc_pkg::CODE_WITHOUT_NULL], code_tally[tsc_pkg::CODE_EXACT],
                 code_tally[tsc_pkg::CODE_BAD_MODE], code_tally[tsc_pkg::CODE_CAPACITY]);
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
